>>> sv/sorted_priority_queue_top_assert.svh
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> sv/spq_pkg.sv
// Types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int KIND_W = 3;
    localparam int KEY_W  = 10;
    localparam int TAG_W  = 8;
    localparam int OCC_W  = 5;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIST   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DRAIN  = 3'd4;

    // Cell array operations
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic [1:0] op;        // cell array operation
        logic       load;      // load the result register
        logic       res_head;  // result carries the head entry
        logic       empty;     // queue_was_empty flag
        logic       dropped;   // insert_dropped flag
        logic       last;      // last result of the request
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/spq_ctrl.sv
// Controller of the sorted priority queue: request decode and burst sequencing.
`default_nettype none

module spq_ctrl import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [KIND_W-1:0] kind,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire sts_t              sts,
    input  wire logic [CNT_W-1:0]  count,
    output cmd_t                   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             drain_reg, drain_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;
    logic             acc;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    // Decode and sequencing
    always_comb begin
        cmd         = '0;
        cmd.op      = OP_NONE;
        state_next  = state_reg;
        remain_next = remain_reg;
        drain_next  = drain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.load = 1'b1;
                    cmd.last = 1'b1;
                    case (kind)
                        KIND_INSERT: begin
                            if (sts.full) begin
                                cmd.dropped = 1'b1;
                            end else begin
                                cmd.op = OP_INS;
                            end
                        end
                        KIND_REMOVE, KIND_PEEK: begin
                            if (sts.empty) begin
                                cmd.empty = 1'b1;
                            end else begin
                                cmd.res_head = 1'b1;
                                cmd.op = (kind == KIND_REMOVE) ? OP_POP : OP_NONE;
                            end
                        end
                        KIND_LIST, KIND_DRAIN: begin
                            if (sts.empty) begin
                                cmd.empty = 1'b1;
                            end else begin
                                cmd.res_head = 1'b1;
                                cmd.op   = (kind == KIND_DRAIN) ? OP_POP : OP_ROT;
                                cmd.last = sts.one;
                                if (!sts.one) begin
                                    state_next  = ST_RUN;
                                    remain_next = count - CNT_W'(1);
                                    drain_next  = (kind == KIND_DRAIN);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    cmd.load     = 1'b1;
                    cmd.res_head = 1'b1;
                    cmd.op       = drain_reg ? OP_POP : OP_ROT;
                    cmd.last     = (remain_reg == CNT_W'(1));
                    remain_next  = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result beat valid
    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            remain_reg  <= '0;
            drain_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            remain_reg  <= remain_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/spq_dp.sv
// Datapath of the sorted priority queue: sorted cell array, count and result register.
`default_nettype none

module spq_dp import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    input  wire logic [KEY_W-1:0] new_key,
    input  wire logic [TAG_W-1:0] new_tag,
    output logic [CNT_W-1:0]      count,
    output sts_t                  sts,
    output logic [KEY_W-1:0]      entry_key,
    output logic [TAG_W-1:0]      entry_tag,
    output logic                  entry_valid,
    output logic                  queue_was_empty,
    output logic                  insert_dropped,
    output logic [OCC_W-1:0]      occupancy,
    output logic                  last_result
);

    logic [KEY_W-1:0] key_reg [QUEUE_DEPTH];
    logic [KEY_W-1:0] key_next [QUEUE_DEPTH];
    logic [TAG_W-1:0] tag_reg [QUEUE_DEPTH];
    logic [TAG_W-1:0] tag_next [QUEUE_DEPTH];
    logic [KEY_W-1:0] key_dn [QUEUE_DEPTH];
    logic [TAG_W-1:0] tag_dn [QUEUE_DEPTH];
    logic [KEY_W-1:0] key_up [QUEUE_DEPTH];
    logic [TAG_W-1:0] tag_up [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le, le_prev;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [KEY_W-1:0] key_out_reg;
    logic [TAG_W-1:0] tag_out_reg;
    logic             valid_out_reg, empty_out_reg, drop_out_reg, last_out_reg;
    logic [OCC_W-1:0] occ_out_reg;

    // Per-cell compare: cell holds an entry that stays ahead of the new one
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CNT_W'(i) < count_reg) && (key_reg[i] <= new_key);
        end
        le_prev[0] = 1'b1;
        key_dn[0]  = new_key;
        tag_dn[0]  = new_tag;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            le_prev[i] = le[i-1];
            key_dn[i]  = key_reg[i-1];
            tag_dn[i]  = tag_reg[i-1];
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            key_up[i] = key_reg[i+1];
            tag_up[i] = tag_reg[i+1];
        end
        key_up[QUEUE_DEPTH-1] = key_reg[QUEUE_DEPTH-1];
        tag_up[QUEUE_DEPTH-1] = tag_reg[QUEUE_DEPTH-1];
    end

    // Next value of each cell
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
            case (cmd.op)
                OP_INS: begin
                    if (!le[i]) begin
                        if (le_prev[i]) begin
                            key_next[i] = new_key;
                            tag_next[i] = new_tag;
                        end else begin
                            key_next[i] = key_dn[i];
                            tag_next[i] = tag_dn[i];
                        end
                    end
                end
                OP_POP: begin
                    key_next[i] = key_up[i];
                    tag_next[i] = tag_up[i];
                end
                OP_ROT: begin
                    // the tail cell takes the head, the rest move up by one
                    if (CNT_W'(i + 1) == count_reg) begin
                        key_next[i] = key_reg[0];
                        tag_next[i] = tag_reg[0];
                    end else begin
                        key_next[i] = key_up[i];
                        tag_next[i] = tag_up[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Entry count
    always_comb begin
        case (cmd.op)
            OP_INS:  count_next = count_reg + CNT_W'(1);
            OP_POP:  count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_out_reg   <= cmd.res_head ? key_reg[0] : '0;
            tag_out_reg   <= cmd.res_head ? tag_reg[0] : '0;
            valid_out_reg <= cmd.res_head;
            empty_out_reg <= cmd.empty;
            drop_out_reg  <= cmd.dropped;
            last_out_reg  <= cmd.last;
            occ_out_reg   <= OCC_W'(count_next);
        end
    end

    assign count     = count_reg;
    assign sts.empty = (count_reg == '0);
    assign sts.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.one   = (count_reg == CNT_W'(1));

    assign entry_key       = key_out_reg;
    assign entry_tag       = tag_out_reg;
    assign entry_valid     = valid_out_reg;
    assign queue_was_empty = empty_out_reg;
    assign insert_dropped  = drop_out_reg;
    assign occupancy       = occ_out_reg;
    assign last_result     = last_out_reg;

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue.
//
//   channel  direction  tdata                        tuser                       tlast
//   s_       in         key[9:0] tag[17:10]          kind[2:0]                   -
//   m_       out        key[9:0] tag[17:10] occ[22:18] valid, empty, dropped     last_result
//
// Insert, remove, peek, empty and unknown requests: one result beat, valid the cycle after
// accept; insert compares every cell with the new key and shifts the tail in that cycle.
// List and drain of n entries: n beats from the head cell, one per cycle while m_tready is high.
// With m_tready high the next request is taken right after the last beat, one per cycle.
// Reset clears the count, the control state and m_tvalid; the cells are not cleared.
// m_tready low holds the result beat and stops both the burst and the input.
`default_nettype none

module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // new_key[9:0], new_tag[17:10], zero pad
    input  wire logic [2:0]  s_tuser,   // kind[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // entry_key[9:0], entry_tag[17:10], occupancy[22:18], pad
    output logic [2:0]       m_tuser,   // entry_valid, queue_was_empty, insert_dropped
    output logic             m_tlast    // last_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             cmd;
    sts_t             sts;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] entry_key;
    logic [TAG_W-1:0] entry_tag;
    logic [OCC_W-1:0] occupancy;
    logic             entry_valid, queue_was_empty, insert_dropped;

    spq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .count    (count),
        .cmd      (cmd)
    );

    spq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .new_key         (s_tdata[9:0]),
        .new_tag         (s_tdata[17:10]),
        .count           (count),
        .sts             (sts),
        .entry_key       (entry_key),
        .entry_tag       (entry_tag),
        .entry_valid     (entry_valid),
        .queue_was_empty (queue_was_empty),
        .insert_dropped  (insert_dropped),
        .occupancy       (occupancy),
        .last_result     (m_tlast)
    );

    assign m_tdata = {1'b0, occupancy, entry_tag, entry_key};
    assign m_tuser = {insert_dropped, queue_was_empty, entry_valid};

endmodule

`default_nettype wire

>>> sv/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
`default_nettype none

`include "sorted_priority_queue_top_assert.svh"

module spq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // a waiting result beat holds its payload
    `SPQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

    // no new request while a result is stuck in the output register
    `SPQ_ASSERT(a_no_accept_stalled, m_tvalid && !m_tready |-> !s_tready, "request taken while result stalled")

    // no new request in the middle of a list or drain burst
    `SPQ_ASSERT(a_burst_blocks_input, m_tvalid && !m_tlast |-> !s_tready, "request taken inside a burst")

    // a dropped insert is a single beat with no entry
    `SPQ_ASSERT(a_drop_single, m_tvalid && m_tuser[2] |-> m_tlast && !m_tuser[0] && !m_tuser[1], "bad dropped-insert beat")

    // no entry means zero key and tag
    `SPQ_ASSERT(a_empty_fields, m_tvalid && !m_tuser[0] |-> m_tdata[17:0] == 18'd0, "entry fields nonzero without an entry")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench of the sorted priority queue top level.
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH     = 16;
    localparam int IDLE_PCT        = 15;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_BLOCKS   = 5;
    localparam int BLOCK_REQUESTS  = 90;
    localparam longint TIMEOUT_NS  = 64'd20_000_000;

    // Kind codes with no command of their own; each still gets one result beat
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             valid;
        logic             empty;
        logic             dropped;
        logic [OCC_W-1:0] occ;
        logic             is_last;
    } beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow copy of the queue contents
    logic [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
    logic [TAG_W-1:0] shadow_tags [QUEUE_DEPTH];
    int               shadow_count;

    beat_t pending_beats[$];

    int  error_count;
    int  requests_sent;
    int  beats_checked;
    int  drops_seen;
    int  holdoff_req;
    bit  tx_idle_on;
    bit  rx_idle_on;

    sorted_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Beat built from the shadow state; occupancy is the count after the update
    function automatic beat_t make_beat(input logic [KEY_W-1:0] key,
                                        input logic [TAG_W-1:0] tag,
                                        input logic valid, input logic empty,
                                        input logic dropped, input logic is_last);
        beat_t b;
        b.key     = key;
        b.tag     = tag;
        b.valid   = valid;
        b.empty   = empty;
        b.dropped = dropped;
        b.occ     = shadow_count[OCC_W-1:0];
        b.is_last = is_last;
        return b;
    endfunction

    task automatic pop_shadow_head();
        int i;
        for (i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_tags[i-1] = shadow_tags[i];
        end
        shadow_count--;
    endtask

    // Updates the shadow queue and queues the beats one request produces
    task automatic predict_request(input logic [KIND_W-1:0] kind,
                                   input logic [KEY_W-1:0] key,
                                   input logic [TAG_W-1:0] tag);
        int               pos;
        int               i;
        int               n;
        logic [KEY_W-1:0] hk;
        logic [TAG_W-1:0] ht;
        case (kind)
            KIND_INSERT: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    pending_beats.push_back(make_beat('0, '0, 1'b0, 1'b0, 1'b1, 1'b1));
                end else begin
                    // after every equal or lower key, so ties stay in arrival order
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= key)
                        pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_tags[i] = shadow_tags[i-1];
                    end
                    shadow_keys[pos] = key;
                    shadow_tags[pos] = tag;
                    shadow_count++;
                    pending_beats.push_back(make_beat('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
                end
            end
            KIND_REMOVE, KIND_PEEK, KIND_LIST, KIND_DRAIN: begin
                if (shadow_count == 0) begin
                    pending_beats.push_back(make_beat('0, '0, 1'b0, 1'b1, 1'b0, 1'b1));
                end else if (kind == KIND_REMOVE || kind == KIND_PEEK) begin
                    hk = shadow_keys[0];
                    ht = shadow_tags[0];
                    if (kind == KIND_REMOVE)
                        pop_shadow_head();
                    pending_beats.push_back(make_beat(hk, ht, 1'b1, 1'b0, 1'b0, 1'b1));
                end else if (kind == KIND_LIST) begin
                    n = shadow_count;
                    for (i = 0; i < n; i++)
                        pending_beats.push_back(make_beat(shadow_keys[i], shadow_tags[i],
                                                          1'b1, 1'b0, 1'b0, i == n - 1));
                end else begin
                    while (shadow_count > 0) begin
                        hk = shadow_keys[0];
                        ht = shadow_tags[0];
                        pop_shadow_head();
                        pending_beats.push_back(make_beat(hk, ht, 1'b1, 1'b0, 1'b0,
                                                          shadow_count == 0));
                    end
                end
            end
            default: begin
                pending_beats.push_back(make_beat('0, '0, 1'b0, 1'b0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // Sends one request; entered and left just after a falling edge
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [KEY_W-1:0] key,
                                input logic [TAG_W-1:0] tag);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, tag, key};
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        if (kind == KIND_INSERT && shadow_count >= QUEUE_DEPTH)
            drops_seen++;
        predict_request(kind, key, tag);
        requests_sent++;
        @(negedge aclk);
    endtask

    // Stops offering requests until every queued beat has come back
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // A quarter small keys to force ties, a quarter extremes, the rest anywhere
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
    endfunction

    // Every command on an empty queue, plus the unused kind codes
    task automatic test_empty_queue();
        send_request(KIND_REMOVE, '1, '1);
        send_request(KIND_PEEK, '0, '0);
        send_request(KIND_LIST, '1, '0);
        send_request(KIND_DRAIN, '0, '1);
        send_request(KIND_SPARE_A, '1, '1);
        send_request(KIND_SPARE_B, '0, '0);
        send_request(KIND_SPARE_C, 10'h155, 8'hAA);
    endtask

    // Extreme keys and tags, ties in arrival order, then read back
    task automatic test_ordering();
        send_request(KIND_INSERT, '1, '1);
        send_request(KIND_INSERT, '0, '0);
        send_request(KIND_INSERT, 10'd512, 8'hAA);
        send_request(KIND_INSERT, 10'd512, 8'h55);
        send_request(KIND_INSERT, '1, '0);
        send_request(KIND_PEEK, '0, '0);
        send_request(KIND_LIST, '0, '0);
        send_request(KIND_REMOVE, '0, '0);
        send_request(KIND_DRAIN, '0, '0);
    endtask

    // Receiver stalls while inserts overfill the queue; then list and drain
    task automatic test_full_queue_backpressure();
        int i;
        holdoff_req <= holdoff_req + 1;
        for (i = 0; i < QUEUE_DEPTH + 2; i++)
            send_request(KIND_INSERT, pick_key(), pick_tag());
        send_request(KIND_LIST, '0, '0);
        send_request(KIND_DRAIN, '0, '0);
    endtask

    // Sender goes quiet until the block has handed back everything
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 6; i++)
            send_request(KIND_INSERT, pick_key(), pick_tag());
        send_request(KIND_LIST, '0, '0);
        wait_until_drained();
        send_request(KIND_PEEK, '0, '0);
        send_request(KIND_DRAIN, '0, '0);
    endtask

    // Weighted random mix; insert share set per block, one block never idles
    task automatic test_random_traffic();
        int blk;
        int counted;
        int insert_pct;
        int pick;
        logic [KIND_W-1:0] kind;
        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            insert_pct = (blk == 0) ? 70 : (blk == 1) ? 55 : (blk == 2) ? 40 : 60;
            tx_idle_on <= (blk != 3);
            rx_idle_on <= (blk != 3);
            counted = 0;
            while (counted < BLOCK_REQUESTS) begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    kind = KIND_INSERT;
                end else begin
                    pick = $urandom_range(0, 99);
                    kind = (pick < 45) ? KIND_REMOVE :
                           (pick < 65) ? KIND_PEEK   :
                           (pick < 80) ? KIND_LIST   :
                           (pick < 94) ? KIND_DRAIN  :
                                         KIND_W'($urandom_range(5, 7));
                end
                send_request(kind, pick_key(), pick_tag());
                if (kind <= KIND_DRAIN)
                    counted++;
            end
            if (blk == 1)
                holdoff_req <= holdoff_req + 1;
        end
    endtask

    // Result side ready: random idling, plus long hold-offs on request
    initial begin
        int stall_left;
        int holdoff_seen;
        stall_left   = 0;
        holdoff_seen = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (holdoff_req != holdoff_seen) begin
                holdoff_seen = holdoff_req;
                stall_left   = HOLDOFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result beat with the oldest expectation
    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.key     = m_tdata[KEY_W-1:0];
            got.tag     = m_tdata[KEY_W+TAG_W-1:KEY_W];
            got.occ     = m_tdata[KEY_W+TAG_W+OCC_W-1:KEY_W+TAG_W];
            got.valid   = m_tuser[0];
            got.empty   = m_tuser[1];
            got.dropped = m_tuser[2];
            got.is_last = m_tlast;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected: key %0d tag %0d",
                       got.key, got.tag);
                error_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("entry_key", want.key, got.key);
                check_field("entry_tag", want.tag, got.tag);
                check_field("entry_valid", want.valid, got.valid);
                check_field("queue_was_empty", want.empty, got.empty);
                check_field("insert_dropped", want.dropped, got.dropped);
                check_field("occupancy", want.occ, got.occ);
                check_field("last_result", want.is_last, got.is_last);
            end
            beats_checked++;
        end
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        shadow_count  = 0;
        error_count   = 0;
        requests_sent = 0;
        beats_checked = 0;
        drops_seen    = 0;
        holdoff_req   = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_queue();
        test_ordering();
        test_full_queue_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_until_drained();

        $display("Sent %0d requests (%0d inserts dropped when full), checked %0d result beats.",
                 requests_sent, drops_seen, beats_checked);
        $display("Covered empty-queue commands, tie order, full-queue drops, long stalls, random mix.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_dp.sv
sv/sorted_priority_queue_top.sv
sv/spq_checker.sv
tb/sv/testbench.sv
